// File: sv/bima_pkg.sv
// Package: shared constants, types and helper functions of the block ID map allocator.
package bima_pkg;

  localparam int unsigned MAX_BLOCKS = 1024;
  localparam int unsigned POS_W      = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W      = POS_W + 1;
  localparam int unsigned ID_W       = 2;
  localparam int unsigned BSZ_W      = 13;
  localparam int unsigned BASE_W     = 24;
  localparam int unsigned REQ_W      = 23;
  localparam int unsigned OFF_W      = 22;
  localparam int unsigned MAX_BSIZE  = 4096;

  localparam logic [ID_W-1:0]  ID_FREE = '0;
  localparam logic [ID_W-1:0]  ID_META = ID_W'(1);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_BLOCKS - 1);

  localparam logic [1:0] FUNC_INIT  = 2'd0;
  localparam logic [1:0] FUNC_ALLOC = 2'd1;
  localparam logic [1:0] FUNC_FREE  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_BAD_OFF = 2'd2;

  localparam logic       CFG_BLOCK_BYTES   = 1'b0;
  localparam logic       CFG_REGION_BLOCKS = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]       status;
    logic [OFF_W-1:0] alloc_offset;
    logic [REQ_W-1:0] freed_bytes;
  } res_t;

  function automatic logic [BSZ_W-1:0] eff_bsize(input logic [BSZ_W-1:0] v);
    logic [BSZ_W-1:0] r;
    if (v == '0) r = BSZ_W'(1);
    else if (v > BSZ_W'(MAX_BSIZE)) r = BSZ_W'(MAX_BSIZE);
    else r = v;
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] eff_blocks(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) r = CNT_W'(1);
    else if (v > CNT_W'(MAX_BLOCKS)) r = CNT_W'(MAX_BLOCKS);
    else r = v;
    return r;
  endfunction

  // smallest nonzero ID differing from both neighbours
  function automatic logic [ID_W-1:0] pick_id(input logic [ID_W-1:0] l,
                                               input logic [ID_W-1:0] r);
    logic [ID_W-1:0] c;
    if (l != ID_W'(1) && r != ID_W'(1)) c = ID_W'(1);
    else if (l != ID_W'(2) && r != ID_W'(2)) c = ID_W'(2);
    else c = ID_W'(3);
    return c;
  endfunction

endpackage

// File: sv/bima_cell.sv
// Ring cell: holds the ID of one block and passes it on while the ring turns.
module bima_cell
  import bima_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [ID_W-1:0] id_i,
  output logic [ID_W-1:0] id_o
);

  logic [ID_W-1:0] id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q <= ID_FREE;
    end else if (en_i) begin
      id_q <= id_i;
    end
  end

  assign id_o = id_q;

endmodule

// File: sv/bima_seq.sv
// Sequencer: watches the ring head each cycle and runs init, allocate and free passes.
module bima_seq
  import bima_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [1:0]       func_i,
  input  logic [REQ_W-1:0] req_i,
  input  logic [OFF_W-1:0] off_i,
  input  logic [BSZ_W-1:0] block_bytes_i,
  input  logic [CNT_W-1:0] region_blocks_i,
  input  logic [ID_W-1:0]  head_id_i,
  input  logic             res_ready_i,
  output logic             idle_o,
  output logic             shift_o,
  output logic [ID_W-1:0]  tail_id_o,
  output logic             res_valid_o,
  output res_t             res_o
);

  state_e state_q, state_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [1:0]        func_q, func_d;
  logic [REQ_W-1:0]  req_q, req_d;
  logic [OFF_W-1:0]  off_q, off_d;
  logic [BASE_W-1:0] base_q, base_d;
  logic              run_q, run_d;
  logic [BASE_W-1:0] acc_q, acc_d;
  logic              found_q, found_d;
  logic              zero_q, zero_d;
  logic [POS_W-1:0]  start_q, start_d;
  logic [POS_W-1:0]  end_q, end_d;
  logic [BASE_W-1:0] sbase_q, sbase_d;
  logic [ID_W-1:0]   left_q, left_d;
  logic [ID_W-1:0]   right_q, right_d;
  logic              pend_q, pend_d;
  logic [ID_W-1:0]   last_q, last_d;
  logic [ID_W-1:0]   nid_q, nid_d;
  logic              ok_q, ok_d;
  logic              hit_q, hit_d;
  logic              bad_q, bad_d;
  logic [ID_W-1:0]   fid_q, fid_d;
  logic [POS_W-1:0]  sblk_q, sblk_d;
  logic              clr_q, clr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [REQ_W-1:0]  freed_q, freed_d;
  logic [CNT_W-1:0]  meta_q, meta_d;
  logic [CNT_W-1:0]  hint_q, hint_d;
  logic [CNT_W-1:0]  used_q, used_d;
  res_t              res_q, res_d;

  logic [BSZ_W-1:0]  bsz;
  logic [CNT_W-1:0]  tblk;
  logic [BASE_W-1:0] meta_bytes;
  logic [CNT_W-1:0]  avail;
  logic [BASE_W-1:0] avail_bytes;
  logic              in_range;
  logic              at_hint;
  logic [BASE_W-1:0] acc_next;
  logic [BASE_W-1:0] base_end;
  logic [ID_W-1:0]   new_id;
  logic              pass_end;
  logic [CNT_W-1:0]  run_len;

  assign bsz        = eff_bsize(block_bytes_i);
  assign tblk       = eff_blocks(region_blocks_i);
  assign meta_bytes = BASE_W'((tblk + CNT_W'(3)) >> 2);
  assign avail      = (tblk > used_q) ? tblk - used_q : '0;
  assign avail_bytes = BASE_W'(avail) * BASE_W'(bsz);
  assign in_range   = {1'b0, pos_q} < tblk;
  assign at_hint    = {1'b0, pos_q} >= hint_q;
  assign acc_next   = (run_q ? acc_q : '0) + BASE_W'(bsz);
  assign base_end   = base_q + BASE_W'(bsz);
  assign pass_end   = (pos_q == POS_LAST);
  assign run_len    = CNT_W'(end_q) - CNT_W'(start_q) + CNT_W'(1);

  // datapath
  always_comb begin
    pos_d = pos_q; func_d = func_q; req_d = req_q; off_d = off_q;
    base_d = base_q; run_d = run_q; acc_d = acc_q; found_d = found_q;
    zero_d = zero_q; start_d = start_q; end_d = end_q; sbase_d = sbase_q;
    left_d = left_q; right_d = right_q; pend_d = pend_q; last_d = last_q;
    nid_d = nid_q; ok_d = ok_q; hit_d = hit_q; bad_d = bad_q; fid_d = fid_q;
    sblk_d = sblk_q; clr_d = clr_q; cnt_d = cnt_q; freed_d = freed_q;
    meta_d = meta_q; hint_d = hint_q; used_d = used_q; res_d = res_q;
    new_id = head_id_i;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          func_d = func_i; req_d = req_i; off_d = off_i;
          ok_d = avail_bytes >= BASE_W'(req_i);
          zero_d = (req_i == '0);
          pos_d = '0; base_d = '0; run_d = 1'b0; acc_d = '0; found_d = 1'b0;
          pend_d = 1'b0; last_d = ID_FREE; hit_d = 1'b0; bad_d = 1'b0;
          clr_d = 1'b0; cnt_d = '0; freed_d = '0; meta_d = '0;
          left_d = ID_FREE; right_d = ID_FREE;
          res_d = '0;
        end
      end
      S_SCAN: begin
        pos_d  = pos_q + POS_W'(1);
        base_d = base_end;
        last_d = head_id_i;
        unique case (func_q)
          FUNC_INIT: begin
            if (in_range && base_q < meta_bytes) begin
              new_id = ID_META;
              meta_d = meta_q + CNT_W'(1);
            end else begin
              new_id = ID_FREE;
            end
            if (pass_end) begin
              hint_d = meta_d;
              used_d = meta_d;
            end
          end
          FUNC_ALLOC: begin
            if (pend_q) begin
              right_d = head_id_i;
              pend_d  = 1'b0;
            end
            if (!found_q && ok_q && in_range && at_hint) begin
              if (head_id_i == ID_FREE) begin
                if (!run_q) begin
                  start_d = pos_q;
                  sbase_d = base_q;
                  left_d  = (pos_q == '0) ? ID_FREE : last_q;
                end
                run_d = 1'b1;
                acc_d = acc_next;
                if (zero_q) begin
                  found_d = 1'b1;
                  right_d = ID_FREE;
                end else if (acc_next >= BASE_W'(req_q)) begin
                  found_d = 1'b1;
                  end_d   = pos_q;
                  if ({1'b0, pos_q} + CNT_W'(1) < tblk) pend_d = 1'b1;
                  else right_d = ID_FREE;
                end
              end else begin
                run_d = 1'b0;
              end
            end else if (!found_q) begin
              run_d = 1'b0;
            end
            if (pass_end) begin
              nid_d = pick_id(left_d, right_d);
              if (!found_d) res_d.status = ST_NO_FIT;
            end
          end
          FUNC_FREE: begin
            if (clr_q) begin
              if (in_range && head_id_i == fid_q) begin
                new_id  = ID_FREE;
                cnt_d   = cnt_q + CNT_W'(1);
                freed_d = freed_q + REQ_W'(bsz);
              end else begin
                clr_d = 1'b0;
              end
            end else if (!hit_q && in_range && base_q <= BASE_W'(off_q)
                         && BASE_W'(off_q) < base_end) begin
              hit_d  = 1'b1;
              sblk_d = pos_q;
              fid_d  = head_id_i;
              if (base_q < meta_bytes) begin
                bad_d = 1'b1;
              end else if (head_id_i != ID_FREE) begin
                new_id  = ID_FREE;
                clr_d   = 1'b1;
                cnt_d   = CNT_W'(1);
                freed_d = REQ_W'(bsz);
              end
            end
            if (pass_end) begin
              if (!hit_d || bad_d) begin
                res_d.status = ST_BAD_OFF;
              end else begin
                res_d.freed_bytes = freed_d;
                if (fid_d != ID_FREE) begin
                  if ({1'b0, sblk_d} < hint_q) hint_d = {1'b0, sblk_d};
                  used_d = (used_q > cnt_d) ? used_q - cnt_d : '0;
                end
              end
            end
          end
          default: ;
        endcase
      end
      S_WRITE: begin
        pos_d = pos_q + POS_W'(1);
        if (found_q && !zero_q && pos_q >= start_q && pos_q <= end_q) new_id = nid_q;
        if (pass_end) begin
          res_d.alloc_offset = sbase_q[OFF_W-1:0];
          if (!zero_q) begin
            used_d = used_q + run_len;
            if ({1'b0, start_q} == hint_q) hint_d = CNT_W'(end_q) + CNT_W'(1);
          end
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start_i) state_d = (func_i == FUNC_INIT || func_i == FUNC_ALLOC ||
                                      func_i == FUNC_FREE) ? S_SCAN : S_DONE;
      S_SCAN: if (pass_end) state_d = (func_q == FUNC_ALLOC && found_d) ? S_WRITE : S_DONE;
      S_WRITE: if (pass_end) state_d = S_DONE;
      S_DONE: if (res_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    idle_o      = (state_q == S_IDLE);
    shift_o     = (state_q == S_SCAN) || (state_q == S_WRITE);
    res_valid_o = (state_q == S_DONE);
    tail_id_o   = new_id;
    res_o       = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pos_q   <= '0;
      hint_q  <= '0;
      used_q  <= '0;
      run_q   <= 1'b0;
      found_q <= 1'b0;
      pend_q  <= 1'b0;
      hit_q   <= 1'b0;
      clr_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      hint_q  <= hint_d;
      used_q  <= used_d;
      run_q   <= run_d;
      found_q <= found_d;
      pend_q  <= pend_d;
      hit_q   <= hit_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d; req_q <= req_d; off_q <= off_d; base_q <= base_d;
    acc_q <= acc_d; zero_q <= zero_d; start_q <= start_d; end_q <= end_d;
    sbase_q <= sbase_d; left_q <= left_d; right_q <= right_d; last_q <= last_d;
    nid_q <= nid_d; ok_q <= ok_d; bad_q <= bad_d; fid_q <= fid_d;
    sblk_q <= sblk_d; cnt_q <= cnt_d; freed_q <= freed_d; meta_q <= meta_d;
    res_q <= res_d;
  end

`ifndef SYNTHESIS
  a_idle_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> pos_q == '0) else $error("ring not aligned when idle");
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(MAX_BLOCKS)) else $error("used count overflow");
  a_hint_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hint_q <= CNT_W'(MAX_BLOCKS)) else $error("hint overflow");
  a_write_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WRITE |-> found_q) else $error("write pass without a run");
`endif

endmodule

// File: sv/block_id_map_allocator_unit.sv
// Top level: block ID map allocator with a turning ring of block cells.
//
// Usage: items arrive on the s_axis channel (tuser = operation, tdata = request
// bytes and free offset); one result per item leaves on m_axis (tuser = status,
// tdata = allocated offset and freed bytes). The cfg channel writes block size
// (index 0) and region size (index 1) and is always ready; write it only idle.
// The map sits in a ring of MAX_BLOCKS cells that turns once per pass, the
// sequencer reading and rewriting the head cell each cycle of a pass.
// Init and free take one pass; allocate with a fitting run takes two passes, a
// scan pass and a write pass; a failed allocate takes one pass, and an unknown
// operation gives its result without a pass.
// One item at a time; the next is taken once the result sits in the output
// register, even while the receiver stalls it.
// Reset clears the map, hint and used count and loads the default registers.
// A stalled result blocks the next result from leaving the sequencer only.
module block_id_map_allocator_unit
  import bima_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // request_bytes[22:0], free_offset[44:23], zero pad
  input  logic [1:0]  s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // alloc_offset[21:0], freed_bytes[44:22], zero pad
  output logic [1:0]  m_axis_tuser,  // status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i
);

  logic [BSZ_W-1:0] block_bytes_q;
  logic [CNT_W-1:0] region_blocks_q;
  logic             idle, shift, res_valid, res_ready, start;
  logic [ID_W-1:0]  tail_id;
  logic [ID_W-1:0]  ring [MAX_BLOCKS];
  res_t             res;
  res_t             out_q;
  logic             out_valid_q;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = idle;
  assign start         = s_axis_tvalid && idle;
  assign res_ready     = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_bytes_q   <= BSZ_W'(MAX_BSIZE);
      region_blocks_q <= CNT_W'(MAX_BLOCKS);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BLOCK_BYTES:   block_bytes_q   <= cfg_data_i;
        CFG_REGION_BLOCKS: region_blocks_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_ring
    if (k == MAX_BLOCKS - 1) begin : g_tail
      bima_cell u_cell (.clk_i, .rst_ni, .en_i(shift), .id_i(tail_id), .id_o(ring[k]));
    end else begin : g_mid
      bima_cell u_cell (.clk_i, .rst_ni, .en_i(shift), .id_i(ring[k+1]), .id_o(ring[k]));
    end
  end

  bima_seq u_seq (
    .clk_i,
    .rst_ni,
    .start_i        (start),
    .func_i         (s_axis_tuser),
    .req_i          (s_axis_tdata[22:0]),
    .off_i          (s_axis_tdata[44:23]),
    .block_bytes_i  (block_bytes_q),
    .region_blocks_i(region_blocks_q),
    .head_id_i      (ring[0]),
    .res_ready_i    (res_ready),
    .idle_o         (idle),
    .shift_o        (shift),
    .tail_id_o      (tail_id),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {3'b000, out_q.freed_bytes, out_q.alloc_offset};

endmodule
